>>> rtl/core/tap_tempo_beat_clock_core_assert.svh
// -----------------------------------------------------------------------------
// Tap tempo beat clock core: assertion macros
// Shorthand for the clocked, reset-qualified checks used by the port checker.
// -----------------------------------------------------------------------------
`ifndef TAP_TEMPO_BEAT_CLOCK_CORE_ASSERT_SVH
`define TAP_TEMPO_BEAT_CLOCK_CORE_ASSERT_SVH

// Same-cycle implication
`define TTBC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define TTBC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/ttbc_pkg.sv
// -----------------------------------------------------------------------------
// Tap tempo beat clock package
// Widths, codes, payload types and controller/datapath interface structs.
// -----------------------------------------------------------------------------
package ttbc_pkg;

   localparam int TIME_WIDTH    = 32;
   localparam int COUNT_WIDTH   = 16;
   localparam int CFG_WIDTH     = 16;
   localparam int DIV_CNT_WIDTH = $clog2(TIME_WIDTH);

   localparam logic [CFG_WIDTH-1:0] INITIAL_BEAT_RESET = CFG_WIDTH'(500);
   localparam logic [CFG_WIDTH-1:0] FRAME_RESET        = CFG_WIDTH'(50);
   localparam logic [CFG_WIDTH-1:0] LATCH_RESET        = CFG_WIDTH'(2000);
   localparam logic [CFG_WIDTH-1:0] HOLD_RESET_RESET   = CFG_WIDTH'(750);
   localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RESET     = CFG_WIDTH'(200);

   typedef enum logic [1:0] {
      KIND_TICK    = 2'd0,
      KIND_PRESS   = 2'd1,
      KIND_RELEASE = 2'd2,
      KIND_NOP     = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      EV_NONE          = 3'd0,
      EV_BEAT          = 3'd1,
      EV_FRAME         = 3'd2,
      EV_IDLE          = 3'd3,
      EV_SERIES_RESTART = 3'd4,
      EV_TEMPO_UPDATE  = 3'd5,
      EV_TAP_IGNORED   = 3'd6,
      EV_HOLD_RESET    = 3'd7
   } event_type;

   typedef enum logic [2:0] {
      CSR_INITIAL_BEAT  = 3'd0,
      CSR_FRAME         = 3'd1,
      CSR_LATCH_TIMEOUT = 3'd2,
      CSR_HOLD_RESET    = 3'd3,
      CSR_DEBOUNCE      = 3'd4
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_APPLY,
      ST_DIVIDE,
      ST_FINISH,
      ST_RESPOND
   } state_type;

   typedef struct packed {
      kind_type         kind;
      logic [31:0]      now_ms;
   } req_type;

   typedef struct packed {
      event_type        event_res;
      logic [31:0]      beat_length_ms;
      logic             blink;
   } rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic             capture;
      logic             eval;
      logic             tick_beat;
      logic             tick_frame;
      logic             restart;
      logic             add_point;
      logic             release_reset;
      logic             div_step;
      logic             set_quotient;
      logic             load_rsp;
      event_type        event_code;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      kind_type         kind;
      logic             beat_hit;
      logic             frame_hit;
      logic             latch_hit;
      logic             bounce_hit;
      logic             hold_hit;
      logic             div_last;
      logic             quo_zero;
   } status_type;

endpackage

>>> rtl/core/ttbc_dp.sv
// -----------------------------------------------------------------------------
// Tap tempo datapath
// Configuration and tempo state registers, time comparators, restoring
// divider for the series average and the result register.
// -----------------------------------------------------------------------------
module ttbc_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  ttbc_pkg::req_type      req_data,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [2:0]             csr_index,
   input  logic [15:0]            csr_wdata,
   input  ttbc_pkg::cmd_type      cmd,
   output ttbc_pkg::status_type   status,
   output ttbc_pkg::rsp_type      rsp_data
);

   localparam int TW = ttbc_pkg::TIME_WIDTH;
   localparam int CW = ttbc_pkg::COUNT_WIDTH;
   localparam int FW = ttbc_pkg::CFG_WIDTH;
   localparam int NW = ttbc_pkg::DIV_CNT_WIDTH;

   // configuration
   logic [FW-1:0] initial_beat_ff, frame_ff, latch_ff, hold_ff, debounce_ff;

   // tempo state
   logic [TW-1:0] beat_length_ff, beat_length_in;
   logic [TW-1:0] next_beat_ff, next_beat_in;
   logic [TW-1:0] next_frame_ff, next_frame_in;
   logic [TW-1:0] last_press_ff, last_press_in;
   logic [TW-1:0] series_start_ff, series_start_in;
   logic [TW-1:0] series_end_ff, series_end_in;
   logic [CW-1:0] tap_count_ff, tap_count_in;
   logic          blink_ff, blink_in;

   // working registers
   ttbc_pkg::kind_type kind_ff;
   logic [TW-1:0] now_ff;
   logic [TW-1:0] sum_a_ff, sum_b_ff;
   logic          beat_hit_ff, frame_hit_ff, latch_hit_ff, bounce_hit_ff, hold_hit_ff;
   logic [CW-1:0] divisor_ff;
   logic [CW-1:0] rem_ff, rem_in;
   logic [TW-1:0] quo_ff, quo_in;
   logic [NW-1:0] div_cnt_ff, div_cnt_in;
   ttbc_pkg::rsp_type rsp_ff;

   logic [TW-1:0] beat_diff, frame_diff, press_gap, bounce_gap, catch_diff;
   logic [TW-1:0] frame_next, initial_ext;
   logic          late;
   logic [CW-1:0] count_sat;
   logic [CW:0]   trial;
   logic          trial_ge;

   assign initial_ext = TW'(initial_beat_ff);
   assign beat_diff   = now_ff - next_beat_ff;
   assign frame_diff  = now_ff - next_frame_ff;
   assign press_gap   = now_ff - last_press_ff;
   assign bounce_gap  = now_ff - series_end_ff;
   assign frame_next  = now_ff + TW'(frame_ff);

   // catch up when the advanced beat is already due or no more than half a beat away
   assign catch_diff = sum_a_ff - now_ff;
   assign late       = catch_diff[TW-1] || (catch_diff <= (beat_length_ff >> 1));

   assign count_sat = (tap_count_ff == {CW{1'b1}}) ? tap_count_ff : tap_count_ff + CW'(1);

   assign trial    = {rem_ff, quo_ff[TW-1]};
   assign trial_ge = trial >= {1'b0, divisor_ff};

   always_comb begin
      beat_length_in  = beat_length_ff;
      next_beat_in    = next_beat_ff;
      next_frame_in   = next_frame_ff;
      last_press_in   = last_press_ff;
      series_start_in = series_start_ff;
      series_end_in   = series_end_ff;
      tap_count_in    = tap_count_ff;
      blink_in        = blink_ff;
      if (cmd.tick_beat) begin
         next_beat_in  = late ? sum_b_ff : sum_a_ff;
         next_frame_in = frame_next;
         blink_in      = ~blink_ff;
      end
      if (cmd.tick_frame) begin
         next_frame_in = frame_next;
      end
      if (cmd.restart) begin
         series_start_in = now_ff;
         series_end_in   = now_ff;
         tap_count_in    = '0;
         beat_length_in  = initial_ext;
         last_press_in   = now_ff;
      end
      if (cmd.add_point) begin
         series_end_in = now_ff;
         tap_count_in  = count_sat;
      end
      if (cmd.release_reset) begin
         last_press_in  = '0;
         beat_length_in = initial_ext;
      end
      if (cmd.set_quotient) begin
         beat_length_in = quo_ff;
         last_press_in  = now_ff;
      end
   end

   always_comb begin
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      div_cnt_in = div_cnt_ff;
      if (cmd.add_point) begin
         rem_in     = '0;
         quo_in     = now_ff - series_start_ff;
         div_cnt_in = NW'(TW - 1);
      end else if (cmd.div_step) begin
         rem_in     = trial_ge ? CW'(trial - {1'b0, divisor_ff}) : trial[CW-1:0];
         quo_in     = {quo_ff[TW-2:0], trial_ge};
         div_cnt_in = div_cnt_ff - NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         initial_beat_ff <= ttbc_pkg::INITIAL_BEAT_RESET;
         frame_ff        <= ttbc_pkg::FRAME_RESET;
         latch_ff        <= ttbc_pkg::LATCH_RESET;
         hold_ff         <= ttbc_pkg::HOLD_RESET_RESET;
         debounce_ff     <= ttbc_pkg::DEBOUNCE_RESET;
         beat_length_ff  <= TW'(ttbc_pkg::INITIAL_BEAT_RESET);
         next_beat_ff    <= '0;
         next_frame_ff   <= '0;
         last_press_ff   <= '0;
         series_start_ff <= '0;
         series_end_ff   <= '0;
         tap_count_ff    <= '0;
         blink_ff        <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               ttbc_pkg::CSR_INITIAL_BEAT:  initial_beat_ff <= csr_wdata;
               ttbc_pkg::CSR_FRAME:         frame_ff        <= csr_wdata;
               ttbc_pkg::CSR_LATCH_TIMEOUT: latch_ff        <= csr_wdata;
               ttbc_pkg::CSR_HOLD_RESET:    hold_ff         <= csr_wdata;
               ttbc_pkg::CSR_DEBOUNCE:      debounce_ff     <= csr_wdata;
               default: ;
            endcase
         end
         beat_length_ff  <= beat_length_in;
         next_beat_ff    <= next_beat_in;
         next_frame_ff   <= next_frame_in;
         last_press_ff   <= last_press_in;
         series_start_ff <= series_start_in;
         series_end_ff   <= series_end_in;
         tap_count_ff    <= tap_count_in;
         blink_ff        <= blink_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff <= req_data.kind;
         now_ff  <= TW'(req_data.now_ms);
      end
      if (cmd.eval) begin
         beat_hit_ff   <= ~beat_diff[TW-1];
         frame_hit_ff  <= ~frame_diff[TW-1];
         latch_hit_ff  <= press_gap > TW'(latch_ff);
         bounce_hit_ff <= bounce_gap < TW'(debounce_ff);
         hold_hit_ff   <= press_gap > TW'(hold_ff);
         sum_a_ff      <= next_beat_ff + beat_length_ff;
         sum_b_ff      <= now_ff + beat_length_ff;
      end
      if (cmd.add_point) begin
         divisor_ff <= count_sat;
      end
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      div_cnt_ff <= div_cnt_in;
      if (cmd.load_rsp) begin
         rsp_ff.event_res      <= cmd.event_code;
         rsp_ff.beat_length_ms <= 32'(beat_length_ff);
         rsp_ff.blink          <= blink_ff;
      end
   end

   assign status.kind       = kind_ff;
   assign status.beat_hit   = beat_hit_ff;
   assign status.frame_hit  = frame_hit_ff;
   assign status.latch_hit  = latch_hit_ff;
   assign status.bounce_hit = bounce_hit_ff;
   assign status.hold_hit   = hold_hit_ff;
   assign status.div_last   = (div_cnt_ff == '0);
   assign status.quo_zero   = (quo_ff == '0);

   assign rsp_data = rsp_ff;

endmodule

>>> rtl/core/ttbc_ctrl.sv
// -----------------------------------------------------------------------------
// Tap tempo controller
// Sequences one request through evaluate, apply, optional divide and finish, then
// respond, and owns the handshake flags and the pending event code.
// -----------------------------------------------------------------------------
module ttbc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  ttbc_pkg::status_type   status,
   output ttbc_pkg::cmd_type      cmd
);

   ttbc_pkg::state_type state_ff, state_in;
   ttbc_pkg::event_type event_ff, event_in;
   logic                rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ttbc_pkg::ST_IDLE;
         event_ff     <= ttbc_pkg::EV_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         event_ff     <= event_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      event_in       = event_ff;
      cmd            = '0;
      cmd.event_code = event_ff;
      // drop the result once taken
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ttbc_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ttbc_pkg::ST_EVAL;
            end
         end
         ttbc_pkg::ST_EVAL: begin
            cmd.eval = 1'b1;
            state_in = ttbc_pkg::ST_APPLY;
         end
         ttbc_pkg::ST_APPLY: begin
            state_in = ttbc_pkg::ST_RESPOND;
            case (status.kind)
               ttbc_pkg::KIND_TICK: begin
                  if (status.beat_hit) begin
                     cmd.tick_beat = 1'b1;
                     event_in      = ttbc_pkg::EV_BEAT;
                  end else if (status.frame_hit) begin
                     cmd.tick_frame = 1'b1;
                     event_in       = ttbc_pkg::EV_FRAME;
                  end else begin
                     event_in = ttbc_pkg::EV_IDLE;
                  end
               end
               ttbc_pkg::KIND_PRESS: begin
                  if (status.latch_hit) begin
                     cmd.restart = 1'b1;
                     event_in    = ttbc_pkg::EV_SERIES_RESTART;
                  end else if (status.bounce_hit) begin
                     event_in = ttbc_pkg::EV_TAP_IGNORED;
                  end else begin
                     cmd.add_point = 1'b1;
                     state_in      = ttbc_pkg::ST_DIVIDE;
                  end
               end
               ttbc_pkg::KIND_RELEASE: begin
                  if (status.hold_hit) begin
                     cmd.release_reset = 1'b1;
                     event_in          = ttbc_pkg::EV_HOLD_RESET;
                  end else begin
                     event_in = ttbc_pkg::EV_NONE;
                  end
               end
               default: begin
                  event_in = ttbc_pkg::EV_NONE;
               end
            endcase
         end
         ttbc_pkg::ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ttbc_pkg::ST_FINISH;
            end
         end
         ttbc_pkg::ST_FINISH: begin
            state_in = ttbc_pkg::ST_RESPOND;
            if (status.quo_zero) begin
               event_in = ttbc_pkg::EV_TAP_IGNORED;
            end else begin
               cmd.set_quotient = 1'b1;
               event_in         = ttbc_pkg::EV_TEMPO_UPDATE;
            end
         end
         ttbc_pkg::ST_RESPOND: begin
            // hold until the result register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ttbc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ttbc_pkg::ST_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != ttbc_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

>>> rtl/core/tap_tempo_beat_clock_core.sv
// -----------------------------------------------------------------------------
// Tap tempo beat clock core
// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_stall  ttbc_pkg::req_type (kind, now_ms)
// rsp       out        rsp_valid / rsp_stall  ttbc_pkg::rsp_type (event, beat, blink)
// csr       in         csr_valid / csr_ready  csr_index, csr_wdata
//
// A tick, release or no-op goes through evaluate, apply and respond before the next
// request is taken; a press that extends the series also goes through divide and
// finish, the one-bit-per-cycle divider (32 steps) averaging the span over the tap count.
// One request is in flight at a time; a stalled result does not block the next
// accept, but that request then waits in the respond state.
// Reset is synchronous and restores register defaults; csr_ready is always high.
// -----------------------------------------------------------------------------
module tap_tempo_beat_clock_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  ttbc_pkg::req_type   req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output ttbc_pkg::rsp_type   rsp_data,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [2:0]          csr_index,
   input  logic [15:0]         csr_wdata
);

   ttbc_pkg::cmd_type    cmd;
   ttbc_pkg::status_type status;

   assign csr_ready = 1'b1;

   ttbc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   ttbc_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_data  (rsp_data)
   );

endmodule

>>> rtl/core/ttbc_checker.sv
// -----------------------------------------------------------------------------
// Tap tempo port checker
// Watches the top-level ports for handshake and result consistency.
// -----------------------------------------------------------------------------
`include "tap_tempo_beat_clock_core_assert.svh"

module ttbc_checker (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  ttbc_pkg::rsp_type   rsp_data
);

   logic rsp_waiting;
   logic req_taken;
   logic rsp_update;
   logic beat_nonzero;

   assign rsp_waiting  = rsp_valid && rsp_stall;
   assign req_taken    = req_valid && !req_stall;
   assign rsp_update   = rsp_valid && (rsp_data.event_res == ttbc_pkg::EV_TEMPO_UPDATE);
   assign beat_nonzero = (rsp_data.beat_length_ms != 32'd0);

   // a stalled result holds
   `TTBC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_waiting,
      rsp_valid && $stable(rsp_data), "stalled result changed")

   // one request at a time: busy right after an accept
   `TTBC_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_taken, req_stall, "accept while busy")

   // an averaged tempo is never zero
   `TTBC_ASSERT_SAME(a_update_nonzero, clock, reset, rsp_update, beat_nonzero, "zero beat")

endmodule

bind tap_tempo_beat_clock_core ttbc_checker u_ttbc_checker (.*);

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Tap tempo beat clock core testbench
// Drives ticks, tap presses, releases and no-ops through the request channel,
// predicts every result from a shadow copy of the tempo state and the
// registers, and checks each result in order against that prediction while
// both channels idle and stall at random.
// -----------------------------------------------------------------------------
module tb_top;

   localparam int CYCLE_LIMIT     = 500_000;
   localparam int DRAIN_CYCLES    = 64;
   localparam int REPORT_MAX      = 10;
   localparam int HOLD_OFF_CYCLES = 300;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   ttbc_pkg::req_type req_data = '{kind: ttbc_pkg::KIND_NOP, now_ms: '0};
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   ttbc_pkg::rsp_type rsp_data;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [2:0]        csr_index = '0;
   logic [15:0]       csr_wdata = '0;

   // register shadows
   logic [15:0] cfg_initial_beat = ttbc_pkg::INITIAL_BEAT_RESET;
   logic [15:0] cfg_frame        = ttbc_pkg::FRAME_RESET;
   logic [15:0] cfg_latch        = ttbc_pkg::LATCH_RESET;
   logic [15:0] cfg_hold         = ttbc_pkg::HOLD_RESET_RESET;
   logic [15:0] cfg_debounce     = ttbc_pkg::DEBOUNCE_RESET;

   // tempo state shadows
   logic [31:0] beat_len     = 32'(ttbc_pkg::INITIAL_BEAT_RESET);
   logic [31:0] next_beat    = '0;
   logic [31:0] next_frame   = '0;
   logic [31:0] last_press   = '0;
   logic [31:0] series_start = '0;
   logic [31:0] series_end   = '0;
   logic [15:0] taps         = '0;
   logic        blink_q      = 1'b0;

   ttbc_pkg::rsp_type rsp_pending[$];
   logic [31:0] clock_ms = 32'd40000;
   int          items_sent = 0;
   int          mismatches = 0;
   int          cycle_count = 0;
   bit          sender_idle = 1'b0;
   bit          receiver_idle = 1'b0;
   int          hold_off_req = 0;

   tap_tempo_beat_clock_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tap_tempo_beat_clock_core regression: fail");
         $finish;
      end
   end

   // Mostly short gaps, a few long ones
   function automatic int idle_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 90) return $urandom_range(1, 4);
      return $urandom_range(12, 48);
   endfunction

   // Advance the tempo state by one request and return the result it gives
   function automatic ttbc_pkg::rsp_type tempo_predict(ttbc_pkg::req_type r);
      logic [31:0]         now;
      logic [31:0]         diff;
      logic [31:0]         quot;
      ttbc_pkg::event_type ev;
      now = r.now_ms;
      ev  = ttbc_pkg::EV_NONE;
      case (r.kind)
         ttbc_pkg::KIND_TICK: begin
            diff = now - next_beat;
            if (!diff[31]) begin
               next_beat = next_beat + beat_len;
               diff = next_beat - now;
               // catch up when the next beat is behind or within half a beat
               if (diff[31] || diff <= (beat_len >> 1)) next_beat = now + beat_len;
               next_frame = now + 32'(cfg_frame);
               blink_q = ~blink_q;
               ev = ttbc_pkg::EV_BEAT;
            end else begin
               diff = now - next_frame;
               if (!diff[31]) begin
                  next_frame = now + 32'(cfg_frame);
                  ev = ttbc_pkg::EV_FRAME;
               end else begin
                  ev = ttbc_pkg::EV_IDLE;
               end
            end
         end
         ttbc_pkg::KIND_PRESS: begin
            diff = now - last_press;
            if (diff > 32'(cfg_latch)) begin
               series_start = now;
               series_end   = now;
               taps         = '0;
               beat_len     = 32'(cfg_initial_beat);
               last_press   = now;
               ev = ttbc_pkg::EV_SERIES_RESTART;
            end else begin
               diff = now - series_end;
               if (diff < 32'(cfg_debounce)) begin
                  ev = ttbc_pkg::EV_TAP_IGNORED;
               end else begin
                  series_end = now;
                  if (taps != '1) taps = taps + 16'd1;
                  diff = series_end - series_start;
                  quot = diff / 32'(taps);
                  if (quot == '0) begin
                     ev = ttbc_pkg::EV_TAP_IGNORED;
                  end else begin
                     beat_len   = quot;
                     last_press = now;
                     ev = ttbc_pkg::EV_TEMPO_UPDATE;
                  end
               end
            end
         end
         ttbc_pkg::KIND_RELEASE: begin
            diff = now - last_press;
            if (diff > 32'(cfg_hold)) begin
               last_press = '0;
               beat_len   = 32'(cfg_initial_beat);
               ev = ttbc_pkg::EV_HOLD_RESET;
            end
         end
         default: ev = ttbc_pkg::EV_NONE;
      endcase
      return '{event_res: ev, beat_length_ms: beat_len, blink: blink_q};
   endfunction

   // Receiver: random stall runs, plus a long hold-off when one is requested
   always @(posedge clock) begin
      int hold_seen;
      int hold_left;
      int run_left;
      if (hold_off_req != hold_seen) begin
         hold_seen = hold_off_req;
         hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (!receiver_idle) begin
         rsp_stall <= 1'b0;
      end else if (run_left > 0) begin
         run_left--;
      end else begin
         rsp_stall <= ($urandom_range(0, 2) == 0);
         run_left = idle_length();
      end
   end

   always @(posedge clock) begin
      ttbc_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (rsp_pending.size() == 0) begin
            if (mismatches < REPORT_MAX)
               $display("unexpected result: ev=%0d beat=%0d blink=%b",
                        rsp_data.event_res, rsp_data.beat_length_ms, rsp_data.blink);
            mismatches++;
         end else begin
            want = rsp_pending.pop_front();
            if (rsp_data.event_res !== want.event_res
                || rsp_data.beat_length_ms !== want.beat_length_ms
                || rsp_data.blink !== want.blink) begin
               if (mismatches < REPORT_MAX)
                  $display("mismatch: expected ev=%0d beat=%0d blink=%b, %s",
                           want.event_res, want.beat_length_ms, want.blink,
                           $sformatf("got ev=%0d beat=%0d blink=%b",
                                     rsp_data.event_res, rsp_data.beat_length_ms,
                                     rsp_data.blink));
               mismatches++;
            end
         end
      end
   end

   // Offer one request and hold it until accepted; valid stays high for a back-to-back one
   task automatic send_req(ttbc_pkg::kind_type k, logic [31:0] t);
      int gap;
      gap = sender_idle ? idle_length() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{kind: k, now_ms: t};
      do @(posedge clock); while (req_stall);
      rsp_pending.push_back(tempo_predict('{kind: k, now_ms: t}));
      items_sent++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (rsp_pending.size() != 0) @(posedge clock);
   endtask

   task automatic apply_config(logic [15:0] ib, logic [15:0] fr, logic [15:0] lt,
                               logic [15:0] hr, logic [15:0] db);
      ttbc_pkg::csr_index_type regs [5];
      logic [15:0]             vals [5];
      regs = '{ttbc_pkg::CSR_INITIAL_BEAT, ttbc_pkg::CSR_FRAME, ttbc_pkg::CSR_LATCH_TIMEOUT,
               ttbc_pkg::CSR_HOLD_RESET, ttbc_pkg::CSR_DEBOUNCE};
      vals = '{ib, fr, lt, hr, db};
      wait_idle();
      for (int i = 0; i < 5; i++) begin
         csr_valid <= 1'b1;
         csr_index <= regs[i];
         csr_wdata <= vals[i];
         do @(posedge clock); while (!csr_ready);
         case (regs[i])
            ttbc_pkg::CSR_INITIAL_BEAT:  cfg_initial_beat = vals[i];
            ttbc_pkg::CSR_FRAME:         cfg_frame = vals[i];
            ttbc_pkg::CSR_LATCH_TIMEOUT: cfg_latch = vals[i];
            ttbc_pkg::CSR_HOLD_RESET:    cfg_hold = vals[i];
            ttbc_pkg::CSR_DEBOUNCE:      cfg_debounce = vals[i];
            default: ;
         endcase
      end
      csr_valid <= 1'b0;
   endtask

   task automatic tick_run(int n);
      logic [31:0] reach;
      repeat (n) begin
         reach = beat_len / 3;
         if (reach == '0) reach = 32'd1;
         if (reach > 32'd4000) reach = 32'd4000;
         // now and then arrive late by at least a beat
         if ($urandom_range(0, 9) == 0) clock_ms += beat_len + $urandom_range(0, reach * 3);
         else clock_ms += $urandom_range(1, reach);
         send_req(ttbc_pkg::KIND_TICK, clock_ms);
      end
   endtask

   task automatic tap_series(int presses);
      int spacing;
      int step;
      int pick;
      int hold;
      spacing = $urandom_range(32'(cfg_debounce), 32'(cfg_latch));
      send_req(ttbc_pkg::KIND_PRESS, clock_ms);
      repeat (presses - 1) begin
         pick = $urandom_range(0, 99);
         if (pick < 12) step = $urandom_range(0, 32'(cfg_debounce));
         else if (pick < 17) step = 32'(cfg_latch) + $urandom_range(1, 500);
         else step = spacing + $urandom_range(0, 40) - 20;
         if (step < 0) step = 0;
         if (pick >= 85) send_req(ttbc_pkg::KIND_TICK, clock_ms + 32'(step / 2));
         clock_ms += 32'(step);
         send_req(ttbc_pkg::KIND_PRESS, clock_ms);
      end
      if ($urandom_range(0, 1) == 1) hold = $urandom_range(0, 32'(cfg_hold));
      else hold = 32'(cfg_hold) + $urandom_range(1, 1500);
      clock_ms += 32'(hold);
      send_req(ttbc_pkg::KIND_RELEASE, clock_ms);
   endtask

   task automatic run_traffic(int count);
      int target;
      int pick;
      target = items_sent + count;
      while (items_sent < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            tick_run($urandom_range(3, 16));
         end else if (pick < 75) begin
            tap_series($urandom_range(2, 8));
         end else if (pick < 85) begin
            send_req(ttbc_pkg::KIND_PRESS, clock_ms);
            clock_ms += 32'(cfg_hold) + $urandom_range(0, 40) - 32'd20;
            send_req(ttbc_pkg::KIND_RELEASE, clock_ms);
         end else if (pick < 95) begin
            send_req(ttbc_pkg::kind_type'($urandom_range(0, 3)), $urandom());
         end else if ($urandom_range(0, 1) == 1) begin
            clock_ms = $urandom();
         end else begin
            clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
         end
      end
   endtask

   task automatic test_beat_clock();
      send_req(ttbc_pkg::KIND_TICK, 32'd0);
      send_req(ttbc_pkg::KIND_TICK, 32'd10);
      send_req(ttbc_pkg::KIND_TICK, 32'd50);
      send_req(ttbc_pkg::KIND_TICK, 32'd600);
      send_req(ttbc_pkg::KIND_TICK, 32'd1000);
      send_req(ttbc_pkg::KIND_TICK, 32'd1400);
      // next beat lands exactly half a beat ahead
      send_req(ttbc_pkg::KIND_TICK, 32'd1750);
      send_req(ttbc_pkg::KIND_TICK, 32'd9000);
      send_req(ttbc_pkg::KIND_TICK, 32'hFFFF_FFFF);
      send_req(ttbc_pkg::KIND_NOP, 32'hFFFF_FFFF);
   endtask

   task automatic test_tap_series();
      send_req(ttbc_pkg::KIND_PRESS, 32'd20000);
      send_req(ttbc_pkg::KIND_PRESS, 32'd20100);
      send_req(ttbc_pkg::KIND_PRESS, 32'd20450);
      send_req(ttbc_pkg::KIND_PRESS, 32'd20900);
      send_req(ttbc_pkg::KIND_RELEASE, 32'd21000);
      send_req(ttbc_pkg::KIND_RELEASE, 32'd22000);
      send_req(ttbc_pkg::KIND_PRESS, 32'd21900);
      send_req(ttbc_pkg::KIND_PRESS, 32'hFFFF_FF00);
      // series across the time wrap, then a release that looks like a huge hold
      send_req(ttbc_pkg::KIND_PRESS, 32'h0000_0100);
      send_req(ttbc_pkg::KIND_RELEASE, 32'h0000_0000);
   endtask

   task automatic test_zero_average();
      apply_config(16'd0, ttbc_pkg::FRAME_RESET, ttbc_pkg::LATCH_RESET,
                   ttbc_pkg::HOLD_RESET_RESET, 16'd0);
      send_req(ttbc_pkg::KIND_PRESS, 32'd30000);
      send_req(ttbc_pkg::KIND_PRESS, 32'd30000);
      send_req(ttbc_pkg::KIND_PRESS, 32'd30001);
      send_req(ttbc_pkg::KIND_TICK, 32'd30002);
   endtask

   task automatic test_config_extremes();
      sender_idle = 1'b1;
      receiver_idle = 1'b1;
      apply_config(16'd1, 16'd1, 16'd1, 16'd1, 16'd0);
      run_traffic(50);
      apply_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      run_traffic(50);
   endtask

   task automatic test_backpressure();
      apply_config(ttbc_pkg::INITIAL_BEAT_RESET, ttbc_pkg::FRAME_RESET,
                   ttbc_pkg::LATCH_RESET, ttbc_pkg::HOLD_RESET_RESET,
                   ttbc_pkg::DEBOUNCE_RESET);
      sender_idle = 1'b0;
      receiver_idle = 1'b0;
      hold_off_req++;
      tick_run(6);
      tap_series(4);
   endtask

   task automatic test_random();
      sender_idle = 1'b1;
      receiver_idle = 1'b1;
      run_traffic(90);
      sender_idle = 1'b0;
      receiver_idle = 1'b0;
      run_traffic(60);
      apply_config(16'($urandom_range(100, 2000)), 16'($urandom_range(5, 200)),
                   16'($urandom_range(800, 5000)), 16'($urandom_range(100, 2000)),
                   16'($urandom_range(0, 300)));
      sender_idle = 1'b1;
      receiver_idle = 1'b1;
      run_traffic(90);
      apply_config(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
                   16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
                   16'($urandom_range(0, 65535)));
      run_traffic(60);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_beat_clock();
      test_tap_series();
      test_zero_average();
      test_config_extremes();
      test_backpressure();
      test_random();
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("tap_tempo_beat_clock_core regression: pass");
      end else begin
         $display("tap_tempo_beat_clock_core regression: fail");
      end
      $finish;
   end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/ttbc_pkg.sv
rtl/core/ttbc_dp.sv
rtl/core/ttbc_ctrl.sv
rtl/core/tap_tempo_beat_clock_core.sv
rtl/core/ttbc_checker.sv
bench/tb_top.sv
